FILE: rtl/core/ccw_pkg.sv
// Shared types and constants for the text console character writer.
package ccw_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned IDX_W  = 11;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0700;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MOVE,
    ST_FILL,
    ST_RESP
  } seq_state_e;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  // Effect of one put character, from the cursor unit to the sequencer.
  typedef struct packed {
    logic wr_en;
    logic blank;
    logic text;
    logic cur;
    logic scroll;
  } cur_upd_t;

endpackage

FILE: rtl/core/ccw_ram.sv
// Screen cell store: one write port, one read port with registered data.
module ccw_ram #(
  parameter int unsigned Depth = 2000,
  parameter int unsigned AddrW = 11
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [ccw_pkg::CELL_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [ccw_pkg::CELL_W-1:0] rd_data_o
);
  import ccw_pkg::*;

  logic [CELL_W-1:0] mem_q [Depth];
  logic [CELL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/ccw_cursor.sv
// Cursor unit: row, column and tab phase registers and the per-character update.
module ccw_cursor #(
  parameter int unsigned Columns = 80,
  parameter int unsigned Rows    = 25,
  parameter int unsigned TabStop = 4,
  parameter int unsigned AddrW   = 11,
  parameter int unsigned RowW    = 5,
  parameter int unsigned ColW    = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       exec_i,
  input  logic [ccw_pkg::CHAR_W-1:0] char_i,
  output logic [RowW-1:0]            row_o,
  output logic [ColW-1:0]            col_o,
  output logic [AddrW-1:0]           idx_o,
  output logic [AddrW-1:0]           wr_addr_o,
  output ccw_pkg::cur_upd_t          upd_o
);
  import ccw_pkg::*;

  localparam int unsigned RowNW = $clog2(Rows + 1);
  localparam int unsigned ColNW = $clog2(Columns + TabStop + 1);
  localparam int unsigned PhW   = (TabStop > 1) ? $clog2(TabStop) : 1;

  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  col_q;
  logic [PhW-1:0]   ph_q;
  logic [RowNW-1:0] row_d;
  logic [ColNW-1:0] col_d;
  logic [PhW-1:0]   ph_d;
  logic [AddrW-1:0] idx;
  cur_upd_t         upd;

  assign idx = AddrW'(row_q * Columns + col_q);

  always_comb begin
    row_d     = RowNW'(row_q);
    col_d     = ColNW'(col_q);
    ph_d      = ph_q;
    upd       = '0;
    wr_addr_o = idx;
    case (char_i)
      CH_NUL, CH_FF, CH_VT, CH_BEL: begin
      end
      CH_LF: begin
        row_d   = RowNW'(row_q) + RowNW'(1);
        col_d   = '0;
        ph_d    = '0;
        upd.cur = 1'b1;
      end
      CH_CR: begin
        col_d   = '0;
        ph_d    = '0;
        upd.cur = 1'b1;
      end
      CH_TAB: begin
        // advance only when off a stop
        if (ph_q != '0) begin
          col_d   = ColNW'(col_q) + ColNW'(TabStop) - ColNW'(ph_q);
          ph_d    = '0;
          upd.cur = 1'b1;
        end
      end
      CH_BS: begin
        if (col_q != '0) begin
          col_d     = ColNW'(col_q) - ColNW'(1);
          ph_d      = (ph_q == '0) ? PhW'(TabStop - 1) : ph_q - PhW'(1);
          upd.cur   = 1'b1;
          wr_addr_o = idx - AddrW'(1);
        end
        upd.wr_en = 1'b1;
        upd.blank = 1'b1;
        upd.text  = 1'b1;
      end
      default: begin
        col_d     = ColNW'(col_q) + ColNW'(1);
        ph_d      = (ph_q == PhW'(TabStop - 1)) ? '0 : ph_q + PhW'(1);
        upd.wr_en = 1'b1;
        upd.text  = 1'b1;
        upd.cur   = 1'b1;
      end
    endcase

    // wrap to the next line
    if (col_d >= ColNW'(Columns)) begin
      col_d   = '0;
      ph_d    = '0;
      row_d   = row_d + RowNW'(1);
      upd.cur = 1'b1;
    end

    // past the last line: hold on the bottom line and request a scroll
    if (row_d >= RowNW'(Rows)) begin
      row_d      = RowNW'(Rows - 1);
      upd.text   = 1'b1;
      upd.cur    = 1'b1;
      upd.scroll = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      ph_q  <= '0;
    end else if (exec_i) begin
      row_q <= RowW'(row_d);
      col_q <= ColW'(col_d);
      ph_q  <= ph_d;
    end
  end

  assign row_o = row_q;
  assign col_o = col_q;
  assign idx_o = idx;
  assign upd_o = upd;

endmodule

FILE: rtl/core/text_console_character_writer.sv
// Top level of the text console character writer: sequencer, config register, outputs.
//
// After reset the block clears all ROWS*COLUMNS cells (2000 by default) of the
// screen store to grey blanks, one cell per cycle, and busy stays high until
// the sweep ends; attribute writes on the config channel are taken at any time
// (cfg_ready_o is always high). An item is taken when start is high and busy
// is low. A read item or a put that does not scroll passes an execute state,
// which acts on the store, then a result state, in which done_o pulses with
// the result, after which busy drops. A put that runs past the last line
// scrolls: the single write port of the store moves (ROWS-1)*COLUMNS cells
// one line up (reads and writes overlapped) and then blanks the bottom line
// before the result appears. The result is shown for exactly one cycle with
// done_o high; the receiver cannot stall it, so capture it then.
module text_console_character_writer #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode_i,
  input  logic [ccw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [ccw_pkg::ADDR_W-1:0] cell_address_i,
  // result strobe and payload
  output logic                       done_o,
  output logic [ccw_pkg::CELL_W-1:0] cell_data_o,
  output logic [ccw_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [ccw_pkg::COL_W-1:0]  cursor_column_o,
  output logic [ccw_pkg::IDX_W-1:0]  cursor_index_o,
  output logic                       text_changed_o,
  output logic                       cursor_changed_o,
  // attribute config channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ccw_pkg::CHAR_W-1:0] cfg_attribute_i
);
  import ccw_pkg::*;

  localparam int unsigned CELLS    = ROWS * COLUMNS;
  localparam int unsigned AW       = $clog2(CELLS);
  localparam int unsigned RW       = $clog2(ROWS);
  localparam int unsigned CW       = $clog2(COLUMNS);
  localparam int unsigned MOVE_END = (ROWS - 1) * COLUMNS;

  seq_state_e        state_q, state_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              mv_vld_q, mv_vld_d;
  logic [AW-1:0]     mv_addr_q, mv_addr_d;
  logic              text_q, text_d;
  logic              cur_q, cur_d;
  logic              rd_ok_q, rd_ok_d;
  logic [CHAR_W-1:0] attr_q;

  // captured command beat
  logic              op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [ADDR_W-1:0] addr_q;

  logic              accept;
  logic              addr_ok;
  logic              exec;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;
  logic [AW-1:0]     cur_idx;
  logic [AW-1:0]     cur_wr_addr;
  cur_upd_t          upd;

  assign accept      = start && !busy;
  assign addr_ok     = 32'(addr_q) < CELLS;
  assign cfg_ready_o = 1'b1;

  ccw_cursor #(
    .Columns (COLUMNS),
    .Rows    (ROWS),
    .TabStop (TAB_STOP),
    .AddrW   (AW),
    .RowW    (RW),
    .ColW    (CW)
  ) u_cursor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exec_i    (exec),
    .char_i    (ch_q),
    .row_o     (cur_row),
    .col_o     (cur_col),
    .idx_o     (cur_idx),
    .wr_addr_o (cur_wr_addr),
    .upd_o     (upd)
  );

  ccw_ram #(
    .Depth (CELLS),
    .AddrW (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer: ptr_q is the one address counter shared by the clear sweep,
  // the line move and the bottom-line fill.
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    mv_vld_d  = 1'b0;
    mv_addr_d = ptr_q;
    text_d    = text_q;
    cur_d     = cur_q;
    rd_ok_d   = rd_ok_q;
    exec      = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = ptr_q;
    wr_data   = {attr_q, CHAR_W'(0)};
    rd_en     = 1'b0;
    rd_addr   = ptr_q + AW'(COLUMNS);
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = CELL_RESET;
        if (ptr_q == AW'(CELLS - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_q == OP_READ) begin
          // out-of-range addresses read as zero: skip the store access
          rd_en   = addr_ok;
          rd_addr = AW'(addr_q);
          rd_ok_d = addr_ok;
          text_d  = 1'b0;
          cur_d   = 1'b0;
          state_d = ST_RESP;
        end else begin
          exec    = 1'b1;
          wr_en   = upd.wr_en;
          wr_addr = cur_wr_addr;
          wr_data = {attr_q, upd.blank ? CHAR_W'(0) : ch_q};
          text_d  = upd.text;
          cur_d   = upd.cur;
          rd_ok_d = 1'b0;
          if (upd.scroll) begin
            ptr_d   = '0;
            state_d = ST_MOVE;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_MOVE: begin
        // read one line below, write the cell fetched last cycle
        rd_en     = ptr_q < AW'(MOVE_END);
        mv_vld_d  = rd_en;
        mv_addr_d = ptr_q;
        wr_en     = mv_vld_q;
        wr_addr   = mv_addr_q;
        wr_data   = rd_data;
        if (ptr_q == AW'(MOVE_END)) begin
          state_d = ST_FILL;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_FILL: begin
        // blank the new bottom line with the current attribute
        wr_en = 1'b1;
        if (ptr_q == AW'(CELLS - 1)) begin
          state_d = ST_RESP;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ptr_q     <= '0;
      mv_vld_q  <= 1'b0;
      mv_addr_q <= '0;
      text_q    <= 1'b0;
      cur_q     <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      mv_vld_q  <= mv_vld_d;
      mv_addr_q <= mv_addr_d;
      text_q    <= text_d;
      cur_q     <= cur_d;
      rd_ok_q   <= rd_ok_d;
    end
  end

  // Hold the command beat for the execute cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      ch_q   <= char_code_i;
      addr_q <= cell_address_i;
    end
  end

  // Attribute register, written from the config channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      attr_q <= cfg_attribute_i;
    end
  end

  assign busy             = state_q != ST_IDLE;
  assign done_o           = state_q == ST_RESP;
  assign cell_data_o      = rd_ok_q ? rd_data : '0;
  assign cursor_row_o     = ROW_W'(cur_row);
  assign cursor_column_o  = COL_W'(cur_col);
  assign cursor_index_o   = IDX_W'(cur_idx);
  assign text_changed_o   = text_q;
  assign cursor_changed_o = cur_q;

endmodule

FILE: rtl/core/ccw_checker.sv
// Port-level checks for the text console character writer, bound to the top level.
module ccw_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_i,
  input logic [ccw_pkg::CELL_W-1:0] cell_data_i,
  input logic                       text_changed_i,
  input logic                       cursor_changed_i
);
  import ccw_pkg::*;

  // An accepted beat keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // A result only appears while an item is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> busy)
    else $error("result strobe while idle");

  // One strobe per item: the strobe is never held, and busy is low once it ends.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i && !busy)
    else $error("result strobe held or block stayed busy");

  // A read reports no change; a put returns zero cell data.
  a_read_or_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (cell_data_i == '0) || (!text_changed_i && !cursor_changed_i))
    else $error("result mixes read data with change flags");

endmodule

bind text_console_character_writer ccw_checker u_ccw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_i           (done_o),
  .cell_data_i      (cell_data_o),
  .text_changed_i   (text_changed_o),
  .cursor_changed_i (cursor_changed_o)
);

FILE: sim/text_console_character_writer_tb.sv
// Self-checking testbench for the text console character writer: shadow screen, cursor checks.
module text_console_character_writer_tb;
  import ccw_pkg::*;

  localparam int unsigned COLUMNS  = 80;
  localparam int unsigned ROWS     = 25;
  localparam int unsigned TAB_STOP = 4;
  localparam int unsigned CELLS    = ROWS * COLUMNS;

  // Items per random phase; four phases bring the random part to about 1400.
  localparam int unsigned PHASE_BEATS = 350;

  // A scrolling put moves (ROWS-1)*COLUMNS cells and blanks one line. Allow for
  // the clearing pass plus every beat scrolling and idling, roughly five times
  // over.
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  // Quiet time after the last result.
  localparam int unsigned DRAIN_CYCLES = 64;

  // One result, field by field, in port order.
  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [IDX_W-1:0]  cursor_index;
    logic              text_changed;
    logic              cursor_changed;
  } cell_result_t;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct {
    opcode_e           op;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    cell_result_t      want;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              opcode_i;
  logic [CHAR_W-1:0] char_code_i;
  logic [ADDR_W-1:0] cell_address_i;
  logic              done_o;
  logic [CELL_W-1:0] cell_data_o;
  logic [ROW_W-1:0]  cursor_row_o;
  logic [COL_W-1:0]  cursor_column_o;
  logic [IDX_W-1:0]  cursor_index_o;
  logic              text_changed_o;
  logic              cursor_changed_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CHAR_W-1:0] cfg_attribute_i;

  // Shadow copy of the screen store, cursor and attribute register.
  logic [CELL_W-1:0] shadow_cells [CELLS];
  int unsigned       shadow_row;
  int unsigned       shadow_col;
  logic [CHAR_W-1:0] shadow_attr;

  cell_result_t  pending_results [$];
  cell_result_t  oldest;
  directed_row_t directed_rows [$];
  int unsigned   beats_sent;
  int unsigned   sender_idle_pct;
  int unsigned   fail_count;
  int unsigned   cycle_count;

  text_console_character_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .char_code_i     (char_code_i),
    .cell_address_i  (cell_address_i),
    .done_o          (done_o),
    .cell_data_o     (cell_data_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_column_o (cursor_column_o),
    .cursor_index_o  (cursor_index_o),
    .text_changed_o  (text_changed_o),
    .cursor_changed_o(cursor_changed_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_attribute_i (cfg_attribute_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one accepted beat to the shadow console and return its result.
  function automatic cell_result_t predict_console(opcode_e op, logic [CHAR_W-1:0] ch,
                                                   logic [ADDR_W-1:0] addr);
    cell_result_t      res;
    logic [CELL_W-1:0] blank;
    int unsigned       pos;
    int unsigned       gap;
    int unsigned       k;
    res   = '0;
    blank = {shadow_attr, 8'h00};
    if (op == OP_READ) begin
      // Addresses past the screen read as zero; the cursor stays put.
      if (addr < CELLS) res.cell_data = shadow_cells[addr];
    end else begin
      case (ch)
        CH_NUL, CH_FF, CH_VT, CH_BEL: ;
        CH_LF: begin
          shadow_row++;
          shadow_col = 0;
          res.cursor_changed = 1'b1;
        end
        CH_CR: begin
          shadow_col = 0;
          res.cursor_changed = 1'b1;
        end
        CH_TAB: begin
          // Only move when off a stop.
          gap = shadow_col % TAB_STOP;
          if (gap != 0) begin
            shadow_col += TAB_STOP - gap;
            res.cursor_changed = 1'b1;
          end
        end
        CH_BS: begin
          // Step back if possible, then blank whatever is under the cursor.
          if (shadow_col > 0) begin
            shadow_col--;
            res.cursor_changed = 1'b1;
          end
          pos = shadow_row * COLUMNS + shadow_col;
          if (pos < CELLS) shadow_cells[pos] = blank;
          res.text_changed = 1'b1;
        end
        default: begin
          pos = shadow_row * COLUMNS + shadow_col;
          if (pos < CELLS) shadow_cells[pos] = blank | CELL_W'(ch);
          shadow_col++;
          res.text_changed   = 1'b1;
          res.cursor_changed = 1'b1;
        end
      endcase
      if (shadow_col >= COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
        res.cursor_changed = 1'b1;
      end
      // Past the last line: shift everything up one line, blank the bottom.
      if (shadow_row >= ROWS) begin
        for (k = 0; k < (ROWS - 1) * COLUMNS; k++) shadow_cells[k] = shadow_cells[k + COLUMNS];
        for (k = (ROWS - 1) * COLUMNS; k < CELLS; k++) shadow_cells[k] = blank;
        shadow_row         = ROWS - 1;
        res.text_changed   = 1'b1;
        res.cursor_changed = 1'b1;
      end
    end
    res.cursor_row    = ROW_W'(shadow_row);
    res.cursor_column = COL_W'(shadow_col);
    res.cursor_index  = IDX_W'(shadow_row * COLUMNS + shadow_col);
    return res;
  endfunction

  // Present one command beat, hold it until taken, then record its result.
  task automatic send_beat(opcode_e op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr,
                           bit typed, cell_result_t want);
    cell_result_t predicted;
    // Idle the sender at random before the beat.
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    char_code_i    <= ch;
    cell_address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // Taken at this edge: advance the shadow and queue the expectation.
    predicted = predict_console(op, ch, addr);
    pending_results.push_back(typed ? want : predicted);
    beats_sent++;
  endtask

  // Drop start and wait until the block is idle with nothing outstanding.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_attribute(logic [CHAR_W-1:0] value);
    cfg_valid_i     <= 1'b1;
    cfg_attribute_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow_attr = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(opcode_e op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr,
                         bit typed, cell_result_t want);
    directed_row_t row;
    row.op    = op;
    row.ch    = ch;
    row.addr  = addr;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // One random body beat of a text line: mostly printable bytes, with reads,
  // cursor controls, ignored controls and arbitrary bytes mixed in.
  task automatic send_body_beat();
    int unsigned       pick;
    int unsigned       here;
    int unsigned       back;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Read either anywhere (past the screen too) or just behind the cursor.
      if ($urandom_range(0, 1) == 0) begin
        addr = ADDR_W'($urandom_range(0, 2047));
      end else begin
        here = shadow_row * COLUMNS + shadow_col;
        back = $urandom_range(0, 3);
        addr = ADDR_W'(here >= back ? here - back : here);
      end
      send_beat(OP_READ, CHAR_W'($urandom_range(0, 255)), addr, 1'b0, '0);
    end else begin
      if (pick < 15) begin
        ch = CH_TAB;
      end else if (pick < 18) begin
        ch = CH_BS;
      end else if (pick < 20) begin
        ch = CH_CR;
      end else if (pick < 22) begin
        case ($urandom_range(0, 3))
          0: ch = CH_NUL;
          1: ch = CH_BEL;
          2: ch = CH_FF;
          default: ch = CH_VT;
        endcase
      end else if (pick < 30) begin
        ch = CHAR_W'($urandom_range(0, 255));
      end else begin
        ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
      end
      send_beat(OP_PUT, ch, ADDR_W'($urandom_range(0, 2047)), 1'b0, '0);
    end
  endtask

  // A line of text: random length (long ones wrap), then usually a line ending.
  task automatic send_line();
    int unsigned len;
    int unsigned ending;
    len    = $urandom_range(0, 95);
    ending = $urandom_range(0, 99);
    repeat (len) send_body_beat();
    if (ending < 85) begin
      if (ending >= 70) send_beat(OP_PUT, CH_CR, '0, 1'b0, '0);
      send_beat(OP_PUT, CH_LF, '0, 1'b0, '0);
    end
  endtask

  // Check each strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result strobed with no beat outstanding");
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (cell_data_o !== oldest.cell_data) begin
          $error("cell_data: expected %h, got %h", oldest.cell_data, cell_data_o);
          fail_count++;
        end
        if (cursor_row_o !== oldest.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", oldest.cursor_row, cursor_row_o);
          fail_count++;
        end
        if (cursor_column_o !== oldest.cursor_column) begin
          $error("cursor_column: expected %0d, got %0d", oldest.cursor_column, cursor_column_o);
          fail_count++;
        end
        if (cursor_index_o !== oldest.cursor_index) begin
          $error("cursor_index: expected %0d, got %0d", oldest.cursor_index, cursor_index_o);
          fail_count++;
        end
        if (text_changed_o !== oldest.text_changed) begin
          $error("text_changed: expected %b, got %b", oldest.text_changed, text_changed_o);
          fail_count++;
        end
        if (cursor_changed_o !== oldest.cursor_changed) begin
          $error("cursor_changed: expected %b, got %b", oldest.cursor_changed,
                 cursor_changed_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_console_character_writer_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned k;
    // Hold every input at a known value; assert reset from time zero.
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    opcode_i        <= OP_PUT;
    char_code_i     <= '0;
    cell_address_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_attribute_i <= '0;
    fail_count      = 0;
    cycle_count     = 0;
    beats_sent      = 0;
    sender_idle_pct = 0;
    shadow_attr     = ATTR_RESET;
    shadow_row      = 0;
    shadow_col      = 0;
    for (k = 0; k < CELLS; k++) shadow_cells[k] = CELL_RESET;

    // Directed table under the reset attribute. Typed rows are the cases that
    // follow directly from reset: blank cells, reads past the screen, ignored
    // controls, a tab on a stop, a backspace and a return at column zero, a first put and its read-back.
    add_row(OP_READ, 8'hA5, 11'd0,    1'b1, {16'h0700, 5'd0, 7'd0, 11'd0, 1'b0, 1'b0});
    add_row(OP_READ, 8'h5A, 11'd1999, 1'b1, {16'h0700, 5'd0, 7'd0, 11'd0, 1'b0, 1'b0});
    add_row(OP_READ, 8'hFF, 11'd2047, 1'b1, {16'h0000, 5'd0, 7'd0, 11'd0, 1'b0, 1'b0});
    add_row(OP_READ, 8'h00, 11'd2000, 1'b1, {16'h0000, 5'd0, 7'd0, 11'd0, 1'b0, 1'b0});
    add_row(OP_PUT,  CH_NUL, 11'd2047, 1'b1, {16'h0000, 5'd0, 7'd0, 11'd0, 1'b0, 1'b0});
    add_row(OP_PUT,  CH_BEL, 11'd0,   1'b1, {16'h0000, 5'd0, 7'd0, 11'd0, 1'b0, 1'b0});
    add_row(OP_PUT,  CH_FF,  11'd0,   1'b1, {16'h0000, 5'd0, 7'd0, 11'd0, 1'b0, 1'b0});
    add_row(OP_PUT,  CH_VT,  11'd0,   1'b1, {16'h0000, 5'd0, 7'd0, 11'd0, 1'b0, 1'b0});
    add_row(OP_PUT,  CH_TAB, 11'd0,   1'b1, {16'h0000, 5'd0, 7'd0, 11'd0, 1'b0, 1'b0});
    add_row(OP_PUT,  CH_BS,  11'd0,   1'b1, {16'h0000, 5'd0, 7'd0, 11'd0, 1'b1, 1'b0});
    add_row(OP_PUT,  CH_CR,  11'd0,   1'b1, {16'h0000, 5'd0, 7'd0, 11'd0, 1'b0, 1'b1});
    add_row(OP_PUT,  8'hFF,  11'd0,   1'b1, {16'h0000, 5'd0, 7'd1, 11'd1, 1'b1, 1'b1});
    add_row(OP_READ, 8'h00,  11'd0,   1'b1, {16'h07FF, 5'd0, 7'd1, 11'd1, 1'b0, 1'b0});
    // The rest go through the predictor.
    add_row(OP_PUT,  CH_TAB, 11'd0,    1'b0, '0);
    add_row(OP_PUT,  CH_TAB, 11'd0,    1'b0, '0);
    add_row(OP_PUT,  8'h01,  11'd0,    1'b0, '0);
    add_row(OP_PUT,  8'h80,  11'd0,    1'b0, '0);
    add_row(OP_PUT,  8'h7F,  11'd0,    1'b0, '0);
    add_row(OP_PUT,  CH_BS,  11'd0,    1'b0, '0);
    add_row(OP_READ, 8'h00,  11'd5,    1'b0, '0);
    add_row(OP_PUT,  CH_LF,  11'd0,    1'b0, '0);
    add_row(OP_PUT,  8'h20,  11'd0,    1'b0, '0);
    add_row(OP_PUT,  CH_CR,  11'd0,    1'b0, '0);
    add_row(OP_READ, 8'h00,  11'd80,   1'b0, '0);
    add_row(OP_READ, 8'h00,  11'd1920, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait out the clearing pass, then walk the table.
    settle();
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].addr,
                directed_rows[i].typed, directed_rows[i].want);
    end

    // Random text in four phases, each under a new attribute: no idling,
    // sender idle 88%, a receiver-stall phase (the receiver cannot stall, so
    // no idling either), and a sender idle 22% phase.
    for (phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: write_attribute(8'h00);
        1: write_attribute(8'hFF);
        default: write_attribute(CHAR_W'($urandom_range(0, 255)));
      endcase
      case (phase)
        1: sender_idle_pct = 88;
        3: sender_idle_pct = 22;
        default: sender_idle_pct = 0;
      endcase
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) send_line();
    end

    // Drain: every result in, then a quiet stretch to catch stray strobes.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("text_console_character_writer_tb passed");
    end else begin
      $display("text_console_character_writer_tb failed");
    end
    $finish;
  end

endmodule
